// ===== rtl/hamming_descriptor_matcher_defines.svh =====
// hamming_descriptor_matcher_defines.svh: assertion macros for the matcher rtl
// no dependencies; included by the files that carry concurrent checks
`ifndef HAMMING_DESCRIPTOR_MATCHER_DEFINES_SVH
`define HAMMING_DESCRIPTOR_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define HDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdm: same-cycle check failed");
// next-cycle implication, disabled while reset is asserted
`define HDM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdm: next-cycle check failed");
`else
`define HDM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HDM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/hdm_pkg.sv =====
// hdm_pkg: shared widths, codes, types and helpers of the descriptor matcher
// no dependencies; used by the interfaces and every module of the block
package hdm_pkg;

  // default configuration of the top level
  localparam int DEF_MAX_KEYPOINTS = 1024;
  localparam int DEF_DESC_WORDS    = 4;

  // fixed field widths
  localparam int WORD_W        = 64;
  localparam int COMMAND_W     = 2;
  localparam int WORD_INDEX_W  = 2;
  localparam int MAX_DIST_W    = 9;
  localparam int MATCH_INDEX_W = 10;
  localparam int MATCH_DIST_W  = 9;
  localparam int MATCH_COUNT_W = 11;

  localparam logic [MAX_DIST_W-1:0] MAX_DIST_RESET = 9'd50;

  // command codes of an input transaction
  typedef enum logic [COMMAND_W-1:0] {
    CMD_START = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } command_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  // control that travels alongside each scanned entry
  typedef struct packed {
    logic valid;
    logic last;
    logic skip;
  } scan_ctl_t;

  // set bits in one byte
  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/hdm_cfg_if.sv =====
// hdm_cfg_if: configuration write channel carrying the distance threshold
// depends on hdm_pkg
interface hdm_cfg_if import hdm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MAX_DIST_W-1:0] max_distance;

  modport source (output valid, output max_distance, input ready);
  modport sink (input valid, input max_distance, output ready);
endinterface

// ===== rtl/hdm_in_if.sv =====
// hdm_in_if: command channel carrying frame, load and query transactions
// depends on hdm_pkg
interface hdm_in_if import hdm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [COMMAND_W-1:0]    command;
  logic [WORD_W-1:0]       descriptor_word;
  logic [WORD_INDEX_W-1:0] word_index;
  logic                    already_matched;

  modport source (output valid, output command, output descriptor_word,
                  output word_index, output already_matched, input ready);
  modport sink (input valid, input command, input descriptor_word,
                input word_index, input already_matched, output ready);
endinterface

// ===== rtl/hdm_out_if.sv =====
// hdm_out_if: result channel carrying one match report per completed query
// depends on hdm_pkg
interface hdm_out_if import hdm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [MATCH_INDEX_W-1:0] match_index;
  logic [MATCH_DIST_W-1:0]  match_distance;
  logic [MATCH_COUNT_W-1:0] match_count;

  modport source (output valid, output found, output match_index,
                  output match_distance, output match_count, input ready);
  modport sink (input valid, input found, input match_index,
                input match_distance, input match_count, output ready);
endinterface

// ===== rtl/hamming_descriptor_matcher.sv =====
// hamming_descriptor_matcher: top level of the brute-force hamming descriptor matcher
// depends on hdm_pkg, the hdm_*_if interfaces, hdm_store and hdm_dist
//
// Start-frame transactions clear the entry and match counts; a load writes one 64-bit word
// of the next entry and the last word of a descriptor sets that entry's assigned flag.
// A query transaction whose last word is accepted holds the command channel off while
// the controller scans, drains the read and popcount pipeline and waits for the result
// register to be free (an empty store skips scan and drain); the next transaction is
// taken once the controller is back in idle. The scan reads one whole descriptor row per
// cycle from the store memory, so the entry count sets how long it runs.
// The result register lets loads go on while a report waits on the output channel; a
// later query scans as usual and then holds in its result state until that report leaves.
// The threshold register takes a write in any cycle and should only change while idle.
`include "hamming_descriptor_matcher_defines.svh"
module hamming_descriptor_matcher import hdm_pkg::*; #(
  parameter int MAX_KEYPOINTS = DEF_MAX_KEYPOINTS,
  parameter int DESC_WORDS    = DEF_DESC_WORDS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hdm_cfg_if.sink    cfg_i,
  hdm_in_if.sink     in_i,
  hdm_out_if.source  out_o
);

  localparam int AW     = $clog2(MAX_KEYPOINTS);
  localparam int EC_W   = $clog2(MAX_KEYPOINTS + 1);
  localparam int DIST_W = $clog2(DESC_WORDS * WORD_W + 1);
  localparam int CMP_W  = (DIST_W > MAX_DIST_W) ? DIST_W : MAX_DIST_W;

  typedef logic [DESC_WORDS-1:0][WORD_W-1:0] row_t;

  state_e                   state_q, state_d;
  logic [MAX_DIST_W-1:0]    max_dist_q;
  logic [EC_W-1:0]          entry_count_q;
  logic [MATCH_COUNT_W-1:0] matches_q;
  row_t                     qbuf_q;
  logic [AW-1:0]            scan_idx_q, scan_idx_d;
  logic [CMP_W-1:0]         best_dist_q, best_dist_d;
  logic [AW-1:0]            best_idx_q, best_idx_d;
  logic                     hit_q, hit_d;
  scan_ctl_t                rd_ctl_q, rd_ctl_d;
  logic [AW-1:0]            rd_idx_q;
  logic                     out_valid_q;
  logic                     out_found_q;
  logic [MATCH_INDEX_W-1:0] out_index_q;
  logic [MATCH_DIST_W-1:0]  out_dist_q;
  logic [MATCH_COUNT_W-1:0] out_count_q;

  logic                     in_ready, in_acc, widx_ok, is_last;
  logic                     cmd_start, cmd_load, cmd_query;
  logic                     store_full, load_we, load_done, qbuf_we, query_go, frame_clr;
  logic                     rd_en, rd_last, out_load;
  logic                     flag_we, flag_data;
  logic [AW-1:0]            flag_addr;
  row_t                     st_row;
  logic                     st_flag;
  scan_ctl_t                dist_in_ctl, dist_ctl;
  logic [AW-1:0]            dist_idx;
  logic [DIST_W-1:0]        row_dist;

  // threshold register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MAX_DIST_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      max_dist_q <= cfg_i.max_distance;
    end
  end

  // command decode
  assign in_ready   = (state_q == ST_IDLE);
  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;
  assign widx_ok    = (32'(in_i.word_index) < 32'(DESC_WORDS));
  assign is_last    = (32'(in_i.word_index) == 32'(DESC_WORDS - 1));
  assign cmd_start  = (in_i.command == CMD_START);
  assign cmd_load   = (in_i.command == CMD_LOAD);
  assign cmd_query  = (in_i.command == CMD_QUERY);
  assign store_full = (entry_count_q >= EC_W'(MAX_KEYPOINTS));
  assign frame_clr  = in_acc && cmd_start;
  assign load_we    = in_acc && cmd_load && widx_ok && !store_full;
  assign load_done  = load_we && is_last;
  assign qbuf_we    = in_acc && cmd_query && widx_ok;
  assign query_go   = qbuf_we && is_last;

  // controller
  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    rd_en      = 1'b0;
    rd_last    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (query_go) begin
          scan_idx_d = '0;
          state_d    = (entry_count_q == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en      = 1'b1;
        rd_last    = ((EC_W'(scan_idx_q) + EC_W'(1)) == entry_count_q);
        scan_idx_d = scan_idx_q + AW'(1);
        if (rd_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dist_ctl.valid && dist_ctl.last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        out_load = !out_valid_q || out_o.ready;
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
    end
  end

  // entry and match counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      matches_q     <= '0;
    end else begin
      if (frame_clr) begin
        entry_count_q <= '0;
        matches_q     <= '0;
      end else begin
        if (load_done) begin
          entry_count_q <= entry_count_q + EC_W'(1);
        end
        if (out_load && hit_q) begin
          matches_q <= matches_q + MATCH_COUNT_W'(1);
        end
      end
    end
  end

  // query buffer
  always_ff @(posedge clk_i) begin
    for (int w = 0; w < DESC_WORDS; w++) begin
      if (qbuf_we && (32'(in_i.word_index) == 32'(w))) begin
        qbuf_q[w] <= in_i.descriptor_word;
      end
    end
  end

  // flag write: load sets the initial flag, a match marks the winner
  assign flag_we   = load_done || (out_load && hit_q);
  assign flag_addr = load_done ? entry_count_q[AW-1:0] : best_idx_q;
  assign flag_data = load_done ? in_i.already_matched : 1'b1;

  hdm_store #(
    .MAX_KEYPOINTS (MAX_KEYPOINTS),
    .DESC_WORDS    (DESC_WORDS),
    .AW            (AW)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (load_we),
    .wr_addr_i   (entry_count_q[AW-1:0]),
    .wr_word_i   (in_i.word_index),
    .wr_data_i   (in_i.descriptor_word),
    .flag_we_i   (flag_we),
    .flag_addr_i (flag_addr),
    .flag_data_i (flag_data),
    .rd_en_i     (rd_en),
    .rd_addr_i   (scan_idx_q),
    .rd_row_o    (st_row),
    .rd_flag_o   (st_flag)
  );

  // tag aligned with the memory read latency
  always_comb begin
    rd_ctl_d       = '0;
    rd_ctl_d.valid = rd_en;
    rd_ctl_d.last  = rd_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q <= '0;
    end else begin
      rd_ctl_q <= rd_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_idx_q <= scan_idx_q;
    end
  end

  always_comb begin
    dist_in_ctl       = rd_ctl_q;
    dist_in_ctl.skip  = st_flag;
  end

  hdm_dist #(
    .DESC_WORDS (DESC_WORDS),
    .IDX_W      (AW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (dist_in_ctl),
    .idx_i   (rd_idx_q),
    .row_i   (st_row),
    .query_i (qbuf_q),
    .ctl_o   (dist_ctl),
    .idx_o   (dist_idx),
    .dist_o  (row_dist)
  );

  // best-so-far tracking, strict compare keeps the lowest index on a tie
  always_comb begin
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    hit_d       = hit_q;
    if (query_go) begin
      best_dist_d = CMP_W'(max_dist_q);
      best_idx_d  = '0;
      hit_d       = 1'b0;
    end else if (dist_ctl.valid && !dist_ctl.skip && (CMP_W'(row_dist) < best_dist_q)) begin
      best_dist_d = CMP_W'(row_dist);
      best_idx_d  = dist_idx;
      hit_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= '0;
      best_idx_q  <= '0;
      hit_q       <= 1'b0;
    end else begin
      best_dist_q <= best_dist_d;
      best_idx_q  <= best_idx_d;
      hit_q       <= hit_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= hit_q;
      out_index_q <= hit_q ? MATCH_INDEX_W'(best_idx_q) : '0;
      out_dist_q  <= hit_q ? MATCH_DIST_W'(best_dist_q) : '0;
      out_count_q <= hit_q ? (matches_q + MATCH_COUNT_W'(1)) : matches_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.found          = out_found_q;
  assign out_o.match_index    = out_index_q;
  assign out_o.match_distance = out_dist_q;
  assign out_o.match_count    = out_count_q;

  // checks
  `HDM_ASSERT_IMP(a_rd_in_range, clk_i, rst_ni, rd_en, EC_W'(scan_idx_q) < entry_count_q)
  `HDM_ASSERT_IMP(a_best_in_range, clk_i, rst_ni, hit_q && state_q != ST_IDLE, EC_W'(best_idx_q) < entry_count_q)
  `HDM_ASSERT_IMP(a_dist_in_scan, clk_i, rst_ni, dist_ctl.valid, state_q == ST_SCAN || state_q == ST_DRAIN)
  `HDM_ASSERT_NXT(a_count_step, clk_i, rst_ni, out_load && hit_q, matches_q == $past(matches_q) + MATCH_COUNT_W'(1))

endmodule

// ===== rtl/hdm_store.sv =====
// hdm_store: descriptor row memory and assigned-flag memory, one read port each
// depends on hdm_pkg; read data is registered
module hdm_store import hdm_pkg::*; #(
  parameter int MAX_KEYPOINTS = DEF_MAX_KEYPOINTS,
  parameter int DESC_WORDS    = DEF_DESC_WORDS,
  parameter int AW            = $clog2(DEF_MAX_KEYPOINTS)
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [AW-1:0]                    wr_addr_i,
  input  logic [WORD_INDEX_W-1:0]          wr_word_i,
  input  logic [WORD_W-1:0]                wr_data_i,
  input  logic                             flag_we_i,
  input  logic [AW-1:0]                    flag_addr_i,
  input  logic                             flag_data_i,
  input  logic                             rd_en_i,
  input  logic [AW-1:0]                    rd_addr_i,
  output logic [DESC_WORDS-1:0][WORD_W-1:0] rd_row_o,
  output logic                             rd_flag_o
);

  logic [DESC_WORDS-1:0][WORD_W-1:0] desc_mem_q [MAX_KEYPOINTS];
  logic                              flag_mem_q [MAX_KEYPOINTS];
  logic [DESC_WORDS-1:0][WORD_W-1:0] rd_row_q;
  logic                              rd_flag_q;

  // word-masked write of one descriptor word
  always_ff @(posedge clk_i) begin
    for (int w = 0; w < DESC_WORDS; w++) begin
      if (wr_en_i && (32'(wr_word_i) == 32'(w))) begin
        desc_mem_q[wr_addr_i][w] <= wr_data_i;
      end
    end
  end

  // flag write, shared by loads and match marking
  always_ff @(posedge clk_i) begin
    if (flag_we_i) begin
      flag_mem_q[flag_addr_i] <= flag_data_i;
    end
  end

  // registered read of a whole row and its flag
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q  <= desc_mem_q[rd_addr_i];
      rd_flag_q <= flag_mem_q[rd_addr_i];
    end
  end

  assign rd_row_o  = rd_row_q;
  assign rd_flag_o = rd_flag_q;

endmodule

// ===== rtl/hdm_dist.sv =====
// hdm_dist: three-stage hamming distance pipeline between a stored row and the query
// depends on hdm_pkg; tags (control and index) travel with the data
module hdm_dist import hdm_pkg::*; #(
  parameter int DESC_WORDS = DEF_DESC_WORDS,
  parameter int IDX_W      = $clog2(DEF_MAX_KEYPOINTS)
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  scan_ctl_t                                  ctl_i,
  input  logic [IDX_W-1:0]                           idx_i,
  input  logic [DESC_WORDS*WORD_W-1:0]               row_i,
  input  logic [DESC_WORDS*WORD_W-1:0]               query_i,
  output scan_ctl_t                                  ctl_o,
  output logic [IDX_W-1:0]                           idx_o,
  output logic [$clog2(DESC_WORDS*WORD_W+1)-1:0]     dist_o
);

  localparam int NB     = DESC_WORDS * WORD_W / 8;
  localparam int DIST_W = $clog2(DESC_WORDS * WORD_W + 1);

  logic [DESC_WORDS*WORD_W-1:0] diff;
  logic [3:0]                   bcnt_q [NB];
  logic [6:0]                   wsum_d [DESC_WORDS];
  logic [6:0]                   wsum_q [DESC_WORDS];
  logic [DIST_W-1:0]            dist_d;
  logic [DIST_W-1:0]            dist_q;
  scan_ctl_t                    ctl1_q, ctl2_q, ctl3_q;
  logic [IDX_W-1:0]             idx1_q, idx2_q, idx3_q;

  assign diff = row_i ^ query_i;

  // tag pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx_i;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
  end

  // stage one: per-byte bit counts
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NB; b++) begin
      bcnt_q[b] <= popcount8(diff[b*8 +: 8]);
    end
  end

  // stage two: per-word sums
  always_comb begin
    for (int w = 0; w < DESC_WORDS; w++) begin
      wsum_d[w] = '0;
      for (int k = 0; k < 8; k++) begin
        wsum_d[w] = wsum_d[w] + 7'(bcnt_q[w*8 + k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < DESC_WORDS; w++) begin
      wsum_q[w] <= wsum_d[w];
    end
  end

  // stage three: descriptor total
  always_comb begin
    dist_d = '0;
    for (int w = 0; w < DESC_WORDS; w++) begin
      dist_d = dist_d + DIST_W'(wsum_q[w]);
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign ctl_o  = ctl3_q;
  assign idx_o  = idx3_q;
  assign dist_o = dist_q;

endmodule
